FILE: design/euler_to_quaternion_unit_assert.svh
// ----------------------------------------------------------------------------
// Euler to quaternion assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`define EULER_TO_QUATERNION_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define E2Q_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("e2q assertion failed");

// Checked at every edge, reset included.
`define E2Q_CHECK_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("e2q reset assertion failed");

`endif

FILE: design/e2q_pkg.sv
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Types, fixed-point constants and helper functions for the conversion pipe.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_FRAC_BITS   = 12;
  localparam int OUT_FRAC_BITS     = 14;
  localparam int WORK_FRAC         = 30;
  localparam int WORK_W            = 34;
  localparam int SC_W              = 32;
  localparam int PROD_W            = 64;
  localparam int AB_W              = 34;
  localparam int TERM_W            = 66;
  localparam int FIN_SHIFT         = 2 * WORK_FRAC - OUT_FRAC_BITS;
  localparam int FIN_W             = TERM_W - FIN_SHIFT;
  localparam int HALF_SHIFT        = WORK_FRAC - 1 - ANGLE_FRAC_BITS;

  localparam logic signed [WORK_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WORK_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [WORK_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [WORK_W-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [FIN_W-1:0] OUT_LIM = FIN_W'(1) <<< OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_t;

  function automatic logic signed [WORK_W-1:0] atan_at(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // Rounds a Q.60 product back to Q.30, half up.
  function automatic logic signed [AB_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + (PROD_W'(1) <<< (WORK_FRAC - 1));
    return s[PROD_W-1:WORK_FRAC];
  endfunction

  // Rounds a Q.60 sum to the output format and clamps it to plus or minus one.
  function automatic logic signed [15:0] finish(input logic signed [TERM_W-1:0] v);
    logic signed [TERM_W-1:0] s;
    logic signed [FIN_W-1:0]  q;
    s = v + (TERM_W'(1) <<< (FIN_SHIFT - 1));
    q = s[TERM_W-1:FIN_SHIFT];
    if (q > OUT_LIM) begin
      q = OUT_LIM;
    end else if (q < -OUT_LIM) begin
      q = -OUT_LIM;
    end
    return q[15:0];
  endfunction

endpackage

FILE: design/e2q_cordic.sv
// ----------------------------------------------------------------------------
// Half-angle sine and cosine
// Halves one angle, reduces and folds it, then runs one CORDIC step a stage.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [15:0]                    angle,
  output logic signed [e2q_pkg::SC_W-1:0]       sin_o,
  output logic signed [e2q_pkg::SC_W-1:0]       cos_o
);

  localparam int N = e2q_pkg::CORDIC_ITERATIONS;
  localparam int W = e2q_pkg::WORK_W;

  logic signed [W-1:0] red_r;
  logic signed [W-1:0] half_ang;
  logic signed [W-1:0] fold_z;
  logic                fold_neg;

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [W-1:0] z_r [0:N];
  logic                neg_r [0:N];

  assign half_ang = W'(angle) <<< e2q_pkg::HALF_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (half_ang > e2q_pkg::PI_Q30) begin
        red_r <= half_ang - e2q_pkg::TWO_PI_Q30;
      end else if (half_ang < -e2q_pkg::PI_Q30) begin
        red_r <= half_ang + e2q_pkg::TWO_PI_Q30;
      end else begin
        red_r <= half_ang;
      end
    end
  end

  always_comb begin
    if (red_r > e2q_pkg::HALF_PI_Q30) begin
      fold_z   = e2q_pkg::PI_Q30 - red_r;
      fold_neg = 1'b1;
    end else if (red_r < -e2q_pkg::HALF_PI_Q30) begin
      fold_z   = -e2q_pkg::PI_Q30 - red_r;
      fold_neg = 1'b1;
    end else begin
      fold_z   = red_r;
      fold_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= e2q_pkg::GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= fold_z;
      neg_r[0] <= fold_neg;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2q_pkg::atan_at(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2q_pkg::atan_at(i);
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  logic signed [W-1:0] cos_full;

  assign cos_full = neg_r[N] ? -x_r[N] : x_r[N];
  assign sin_o    = y_r[N][e2q_pkg::SC_W-1:0];
  assign cos_o    = cos_full[e2q_pkg::SC_W-1:0];

  logic unused_z;
  assign unused_z = ^z_r[N];

endmodule

FILE: design/euler_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// Euler to quaternion unit
// Converts pitch, yaw and roll (Q4.12 radians) to a unit quaternion (Q1.14).
// ----------------------------------------------------------------------------
// The unit takes one attitude transfer per clock while it is not stalled and
// returns its quaternion through the per-angle CORDIC pipes (range reduction,
// quadrant fold and sixteen iterations) and then the registers that form the
// pair products, the triple products and the rounded, clamped sums.
// When the result side stalls with a result waiting, the whole pipe holds
// and the input side is stalled in the same cycle.
module euler_to_quaternion_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  e2q_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output e2q_pkg::out_t out_data
);

  localparam int LAT = e2q_pkg::CORDIC_ITERATIONS + 5;
  localparam int SW  = e2q_pkg::SC_W;
  localparam int PW  = e2q_pkg::PROD_W;
  localparam int AW  = e2q_pkg::AB_W;
  localparam int TW  = e2q_pkg::TERM_W;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  logic signed [SW-1:0] sp, cp, sy, cy, sr, cr;

  e2q_cordic u_pitch (.clk(clk), .en(en), .angle(in_data.pitch_angle), .sin_o(sp), .cos_o(cp));
  e2q_cordic u_yaw   (.clk(clk), .en(en), .angle(in_data.yaw_angle),   .sin_o(sy), .cos_o(cy));
  e2q_cordic u_roll  (.clk(clk), .en(en), .angle(in_data.roll_angle),  .sin_o(sr), .cos_o(cr));

  logic signed [PW-1:0] p_cc_r, p_ss_r, p_sc_r, p_cs_r;
  logic signed [SW-1:0] cy_r, sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cc_r <= PW'(cr * cp);
      p_ss_r <= PW'(sr * sp);
      p_sc_r <= PW'(sr * cp);
      p_cs_r <= PW'(cr * sp);
      cy_r   <= cy;
      sy_r   <= sy;
    end
  end

  logic signed [AW-1:0] ab_cc, ab_ss, ab_sc, ab_cs;

  assign ab_cc = e2q_pkg::round_q30(p_cc_r);
  assign ab_ss = e2q_pkg::round_q30(p_ss_r);
  assign ab_sc = e2q_pkg::round_q30(p_sc_r);
  assign ab_cs = e2q_pkg::round_q30(p_cs_r);

  logic signed [TW-1:0] w0_r, w1_r, x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r <= TW'(ab_cc * cy_r);
      w1_r <= TW'(ab_ss * sy_r);
      x0_r <= TW'(ab_sc * cy_r);
      x1_r <= TW'(ab_cs * sy_r);
      y0_r <= TW'(ab_cs * cy_r);
      y1_r <= TW'(ab_sc * sy_r);
      z0_r <= TW'(ab_cc * sy_r);
      z1_r <= TW'(ab_ss * cy_r);
    end
  end

  e2q_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.quat_w <= e2q_pkg::finish(w0_r + w1_r);
      out_data_r.quat_x <= e2q_pkg::finish(x0_r - x1_r);
      out_data_r.quat_y <= e2q_pkg::finish(y0_r + y1_r);
      out_data_r.quat_z <= e2q_pkg::finish(z0_r - z1_r);
    end
  end

  assign out_data = out_data_r;

endmodule

FILE: design/e2q_checker.sv
// ----------------------------------------------------------------------------
// Euler to quaternion checker
// Port-level assertions on the conversion unit, attached by bind.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_unit_assert.svh"

module e2q_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input e2q_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input e2q_pkg::out_t out_data
);

  logic unused_in;
  assign unused_in = in_valid ^ (^in_data);

  `E2Q_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  `E2Q_CHECK(a_stall_cause, in_stall |-> out_valid && out_stall)
  `E2Q_CHECK(a_unit_range, out_valid |-> (out_data.quat_w >= -16'sd16384) && (out_data.quat_w <= 16'sd16384) && (out_data.quat_x >= -16'sd16384) && (out_data.quat_x <= 16'sd16384) && (out_data.quat_y >= -16'sd16384) && (out_data.quat_y <= 16'sd16384) && (out_data.quat_z >= -16'sd16384) && (out_data.quat_z <= 16'sd16384))
  `E2Q_CHECK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);

FILE: tb/euler_to_quaternion_unit_tb.sv
// ----------------------------------------------------------------------------
// Euler to quaternion unit testbench
// Drives attitude transfers with random sender gaps and receiver stalls,
// predicts each quaternion with an independent fixed-point CORDIC model and
// compares every result field against the oldest expected quaternion.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import e2q_pkg::*;

  localparam longint PI_W      = 64'sd3373259426;
  localparam longint TWO_PI_W  = 64'sd6746518852;
  localparam longint HALF_PI_W = 64'sd1686629713;
  localparam longint GAIN_W    = 64'sd652032874;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  out_t quat_queue[$];
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;

  euler_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void half_angle_trig(logic signed [15:0] raw, output longint s,
                                          output longint c);
    longint t, x, y, z, dx, dy, a;
    bit flip;
    t = longint'(raw) * (64'sd1 <<< (WORK_FRAC - 1 - ANGLE_FRAC_BITS));
    flip = 1'b0;
    t = t % TWO_PI_W;
    if (t > PI_W) begin
      t = t - TWO_PI_W;
    end else if (t < -PI_W) begin
      t = t + TWO_PI_W;
    end
    if (t > HALF_PI_W) begin
      t = PI_W - t;
      flip = 1'b1;
    end else if (t < -HALF_PI_W) begin
      t = -PI_W - t;
      flip = 1'b1;
    end
    x = GAIN_W;
    y = 0;
    z = t;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      a = longint'(atan_at(i));
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= a;
      end else begin
        x += dx;
        y -= dy;
        z += a;
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint triple_product(longint a, longint b, longint c);
    longint ab;
    ab = floor_shift(a * b + (64'sd1 <<< (WORK_FRAC - 1)), WORK_FRAC);
    return ab * c;
  endfunction

  function automatic logic signed [15:0] round_clamp(longint v);
    longint q, lim;
    int sh;
    sh = 2 * WORK_FRAC - OUT_FRAC_BITS;
    lim = 64'sd1 <<< OUT_FRAC_BITS;
    q = floor_shift(v + (64'sd1 <<< (sh - 1)), sh);
    if (q > lim) begin
      q = lim;
    end
    if (q < -lim) begin
      q = -lim;
    end
    return q[15:0];
  endfunction

  function automatic out_t predict_quaternion(in_t att);
    longint sp, cp, sy, cy, sr, cr;
    out_t q;
    half_angle_trig(att.pitch_angle, sp, cp);
    half_angle_trig(att.yaw_angle, sy, cy);
    half_angle_trig(att.roll_angle, sr, cr);
    q.quat_w = round_clamp(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
    q.quat_x = round_clamp(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
    q.quat_y = round_clamp(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
    q.quat_z = round_clamp(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
    return q;
  endfunction

  // The receiver stall is redrawn every falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t exp_q;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected quaternion %h", out_data);
        errors++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (out_data.quat_w !== exp_q.quat_w) begin
          $error("quat_w expected %0d actual %0d", exp_q.quat_w, out_data.quat_w);
          errors++;
        end
        if (out_data.quat_x !== exp_q.quat_x) begin
          $error("quat_x expected %0d actual %0d", exp_q.quat_x, out_data.quat_x);
          errors++;
        end
        if (out_data.quat_y !== exp_q.quat_y) begin
          $error("quat_y expected %0d actual %0d", exp_q.quat_y, out_data.quat_y);
          errors++;
        end
        if (out_data.quat_z !== exp_q.quat_z) begin
          $error("quat_z expected %0d actual %0d", exp_q.quat_z, out_data.quat_z);
          errors++;
        end
      end
    end
  end

  task automatic send_attitude(in_t att);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= att;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    quat_queue.push_back(predict_quaternion(att));
    @(negedge clk);
  endtask

  function automatic in_t random_attitude();
    in_t att;
    att.pitch_angle = 16'($urandom);
    att.yaw_angle = 16'($urandom);
    att.roll_angle = 16'($urandom);
    // Most attitudes stay within one turn so the fold boundaries get exercised.
    if ($urandom_range(3) != 0) begin
      att.pitch_angle = 16'($signed($urandom_range(0, 51472)) - 25736);
      att.yaw_angle = 16'($signed($urandom_range(0, 51472)) - 25736);
      att.roll_angle = 16'($signed($urandom_range(0, 51472)) - 25736);
    end
    return att;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (30) @(negedge clk);
  endtask

  task automatic test_directed_extremes();
    logic signed [15:0] corner[12];
    in_t att;
    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
               16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868, 16'sd12867,
               16'sd25736, -16'sd25736};
    for (int i = 0; i < 12; i++) begin
      att.pitch_angle = corner[i];
      att.yaw_angle = corner[(i + 4) % 12];
      att.roll_angle = corner[(i + 8) % 12];
      send_attitude(att);
    end
    for (int i = 0; i < 12; i++) begin
      att = '{corner[i], corner[i], corner[i]};
      send_attitude(att);
    end
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_attitude(random_attitude());
    end
  endtask

  task automatic test_pause_until_empty();
    drain_results();
    test_random_phase(50, 0, 0);
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_random_phase(300, 0, 0);
    test_random_phase(250, 81, 0);
    test_random_phase(250, 0, 81);
    test_random_phase(250, 16, 16);
    test_pause_until_empty();
    recv_stall_pct = 0;
    drain_results();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/e2q_pkg.sv
design/e2q_cordic.sv
design/euler_to_quaternion_unit.sv
design/e2q_checker.sv
tb/euler_to_quaternion_unit_tb.sv
